@@ hdl/smpd_pkg.sv @@
// Shared types, codes and constants for the signal mask / pending dispatcher.
// Used by smpd_ctrl, smpd_dp and signal_mask_pending_dispatcher_core.
package smpd_pkg;

  localparam int NUM_SIGNALS_DEF = 64;
  localparam int SET_W           = 64;
  localparam int ENTRY_W         = 4;   // {reset, info, kind[1:0]}

  // action codes
  typedef enum logic [2:0] {
    ACT_SET_DISP = 3'd0,
    ACT_MASK     = 3'd1,
    ACT_DELIVER  = 3'd2,
    ACT_TAKE     = 3'd3,
    ACT_READ     = 3'd4
  } action_t;

  // disposition kinds
  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_IGNORE  = 2'd1;
  localparam logic [1:0] KIND_HANDLER = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  // mask change modes
  localparam logic [1:0] HOW_BLOCK   = 2'd0;
  localparam logic [1:0] HOW_UNBLOCK = 2'd1;
  localparam logic [1:0] HOW_SET     = 2'd2;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  // delivery outcomes
  localparam logic [3:0] OUT_NONE      = 4'd0;
  localparam logic [3:0] OUT_LATCHED   = 4'd1;
  localparam logic [3:0] OUT_IGNORED   = 4'd2;
  localparam logic [3:0] OUT_DFL_IGN   = 4'd3;
  localparam logic [3:0] OUT_STOP      = 4'd4;
  localparam logic [3:0] OUT_CONT      = 4'd5;
  localparam logic [3:0] OUT_TERMINATE = 4'd6;
  localparam logic [3:0] OUT_HANDLER   = 4'd7;
  localparam logic [3:0] OUT_HANDLER_I = 4'd8;

  // signal numbers
  localparam logic [5:0] SN_KILL  = 6'd9;
  localparam logic [5:0] SN_PIPE  = 6'd13;
  localparam logic [5:0] SN_CHLD  = 6'd17;
  localparam logic [5:0] SN_CONT  = 6'd18;
  localparam logic [5:0] SN_STOP  = 6'd19;
  localparam logic [5:0] SN_TSTP  = 6'd20;
  localparam logic [5:0] SN_TTIN  = 6'd21;
  localparam logic [5:0] SN_TTOU  = 6'd22;
  localparam logic [5:0] SN_URG   = 6'd23;
  localparam logic [5:0] SN_WINCH = 6'd28;

  localparam logic [7:0] EXIT_BASE = 8'd128;

  localparam logic [SET_W-1:0] KILL_STOP_MASK =
    (SET_W'(1) << SN_KILL) | (SET_W'(1) << SN_STOP);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;  // latch input beat, start table read
    logic commit;   // update state, load output register
  } cmd_t;

  typedef struct packed {
    logic out_blocked;  // output register full and stalled
  } sts_t;

  // table contents after reset
  function automatic logic [ENTRY_W-1:0] reset_entry(input logic [5:0] sig);
    reset_entry = (sig == SN_CHLD || sig == SN_PIPE) ? {2'b00, KIND_IGNORE}
                                                     : {2'b00, KIND_DEFAULT};
  endfunction

endpackage

@@ hdl/smpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smpd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/smpd_ctrl.sv @@
// Controller: two-state sequencer that captures an input beat, then commits it.
// Depends on smpd_pkg.
module smpd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  smpd_pkg::sts_t sts,
  output smpd_pkg::cmd_t cmd
);

  smpd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smpd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smpd_pkg::S_IDLE: begin
        if (in_valid) state_nxt = smpd_pkg::S_EXEC;
      end
      smpd_pkg::S_EXEC: begin
        if (!sts.out_blocked) state_nxt = smpd_pkg::S_IDLE;
      end
      default: state_nxt = smpd_pkg::S_IDLE;
    endcase
  end

  // no beat is taken while reset is held
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      smpd_pkg::S_IDLE: begin
        in_stall    = !rst_n;
        cmd.capture = in_valid && rst_n;
      end
      smpd_pkg::S_EXEC: begin
        cmd.commit = !sts.out_blocked;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/smpd_dp.sv @@
// Datapath: input holding registers, disposition table, blocked/pending masks,
// lowest-pending encoder and output register. Depends on smpd_pkg, smpd_ram.
module smpd_dp #(
  parameter int NUM_SIGNALS = smpd_pkg::NUM_SIGNALS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smpd_pkg::cmd_t             cmd,
  output smpd_pkg::sts_t             sts,
  input  logic [2:0]                 in_action,
  input  logic [5:0]                 in_signal_number,
  input  logic [1:0]                 in_disposition_kind,
  input  logic                       in_wants_info,
  input  logic                       in_reset_once,
  input  logic [1:0]                 in_mask_how,
  input  logic                       in_mask_given,
  input  logic [smpd_pkg::SET_W-1:0] in_signal_set,
  input  logic                       in_info_given,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [3:0]                 out_outcome,
  output logic [7:0]                 out_exit_code,
  output logic [1:0]                 out_old_kind,
  output logic                       out_old_info_flag,
  output logic                       out_old_reset_flag,
  output logic [smpd_pkg::SET_W-1:0] out_set_out,
  output logic [5:0]                 out_taken_signal
);

  localparam int AW = $clog2(NUM_SIGNALS);
  localparam int SW = smpd_pkg::SET_W;
  localparam int EW = smpd_pkg::ENTRY_W;

  // held input beat
  logic [2:0]    action_r;
  logic [5:0]    sig_r;
  logic [1:0]    kind_r;
  logic          winfo_r, wreset_r, given_r, ginfo_r;
  logic [1:0]    how_r;
  logic [SW-1:0] set_r;
  logic          rd_valid_r;

  logic [SW-1:0]          blocked_r, blocked_nxt;
  logic [SW-1:0]          pending_r, pending_nxt;
  logic [NUM_SIGNALS-1:0] valid_r;

  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic [3:0]    outcome_r, outcome_nxt;
  logic [7:0]    exit_r, exit_nxt;
  logic [1:0]    okind_r, okind_nxt;
  logic          oinfo_r, oinfo_nxt, oreset_r, oreset_nxt;
  logic [SW-1:0] setout_r, setout_nxt;
  logic [5:0]    taken_r, taken_nxt;

  logic          in_rng_in, in_rng;
  logic [AW-1:0] raddr, waddr;
  logic [EW-1:0] ram_rdata, entry, wentry;
  logic          tbl_we;

  logic [SW-1:0] take_rng, cand;
  logic [7:0]    grp_any;
  logic [2:0]    grp_idx [8];
  logic [2:0]    grp_sel;

  assign in_rng_in = (in_signal_number != 6'd0) &&
                     ({1'b0, in_signal_number} < 7'(NUM_SIGNALS));
  assign in_rng    = (sig_r != 6'd0) && ({1'b0, sig_r} < 7'(NUM_SIGNALS));
  assign raddr     = in_signal_number[AW-1:0];
  assign waddr     = sig_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r   <= in_action;
      sig_r      <= in_signal_number;
      kind_r     <= in_disposition_kind;
      winfo_r    <= in_wants_info;
      wreset_r   <= in_reset_once;
      how_r      <= in_mask_how;
      given_r    <= in_mask_given;
      set_r      <= in_signal_set;
      ginfo_r    <= in_info_given;
      rd_valid_r <= in_rng_in ? valid_r[raddr] : 1'b0;
    end
  end

  smpd_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SIGNALS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (cmd.capture && in_rng_in),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as their reset disposition
  assign entry = rd_valid_r ? ram_rdata : smpd_pkg::reset_entry(sig_r);

  // lowest pending unblocked signal in the given set: 8 groups of 8, then pick the group
  always_comb begin
    for (int i = 0; i < SW; i++) begin
      take_rng[i] = (i >= 1) && (i < NUM_SIGNALS);
    end
    cand = pending_r & set_r & ~blocked_r & take_rng;
    for (int g = 0; g < 8; g++) begin
      grp_any[g] = |cand[g*8 +: 8];
      grp_idx[g] = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (cand[g*8 + b]) grp_idx[g] = 3'(b);
      end
    end
    grp_sel = 3'd0;
    for (int g = 7; g >= 0; g--) begin
      if (grp_any[g]) grp_sel = 3'(g);
    end
  end

  always_comb begin
    blocked_nxt = blocked_r;
    pending_nxt = pending_r;
    status_nxt  = smpd_pkg::ST_OK;
    outcome_nxt = smpd_pkg::OUT_NONE;
    exit_nxt    = 8'd0;
    okind_nxt   = 2'd0;
    oinfo_nxt   = 1'b0;
    oreset_nxt  = 1'b0;
    setout_nxt  = '0;
    taken_nxt   = 6'd0;
    tbl_we      = 1'b0;
    wentry      = {wreset_r, winfo_r, kind_r};

    unique case (smpd_pkg::action_t'(action_r))
      smpd_pkg::ACT_SET_DISP: begin
        if (!in_rng || sig_r == smpd_pkg::SN_KILL || sig_r == smpd_pkg::SN_STOP) begin
          status_nxt = smpd_pkg::ST_INVALID;
        end else begin
          okind_nxt  = entry[1:0];
          oinfo_nxt  = entry[2];
          oreset_nxt = entry[3];
          if (kind_r == smpd_pkg::KIND_BAD) begin
            status_nxt = smpd_pkg::ST_INVALID;
          end else begin
            tbl_we = cmd.commit;
          end
        end
      end

      smpd_pkg::ACT_MASK: begin
        setout_nxt = blocked_r;
        if (given_r) begin
          case (how_r)
            smpd_pkg::HOW_BLOCK:   blocked_nxt = (blocked_r | set_r) &
                                                 ~smpd_pkg::KILL_STOP_MASK;
            smpd_pkg::HOW_UNBLOCK: blocked_nxt = blocked_r & ~set_r &
                                                 ~smpd_pkg::KILL_STOP_MASK;
            smpd_pkg::HOW_SET:     blocked_nxt = set_r & ~smpd_pkg::KILL_STOP_MASK;
            default:               status_nxt  = smpd_pkg::ST_INVALID;
          endcase
        end
      end

      smpd_pkg::ACT_DELIVER: begin
        if (!in_rng) begin
          status_nxt = smpd_pkg::ST_INVALID;
        end else if (blocked_r[sig_r]) begin
          pending_nxt[sig_r] = 1'b1;
          outcome_nxt        = smpd_pkg::OUT_LATCHED;
        end else begin
          case (entry[1:0])
            smpd_pkg::KIND_IGNORE: outcome_nxt = smpd_pkg::OUT_IGNORED;
            smpd_pkg::KIND_HANDLER: begin
              if (entry[2]) begin
                outcome_nxt = ginfo_r ? smpd_pkg::OUT_HANDLER_I : smpd_pkg::OUT_NONE;
              end else begin
                outcome_nxt = smpd_pkg::OUT_HANDLER;
              end
              // one-shot handler reverts to default, reset flag kept
              if (entry[3]) begin
                wentry = {1'b1, 1'b0, smpd_pkg::KIND_DEFAULT};
                tbl_we = cmd.commit;
              end
            end
            smpd_pkg::KIND_DEFAULT: begin
              if (sig_r == smpd_pkg::SN_CHLD || sig_r == smpd_pkg::SN_URG ||
                  sig_r == smpd_pkg::SN_WINCH) begin
                outcome_nxt = smpd_pkg::OUT_DFL_IGN;
              end else if (sig_r == smpd_pkg::SN_STOP || sig_r == smpd_pkg::SN_TSTP ||
                           sig_r == smpd_pkg::SN_TTIN || sig_r == smpd_pkg::SN_TTOU) begin
                outcome_nxt = smpd_pkg::OUT_STOP;
              end else if (sig_r == smpd_pkg::SN_CONT) begin
                outcome_nxt = smpd_pkg::OUT_CONT;
              end else begin
                outcome_nxt = smpd_pkg::OUT_TERMINATE;
                exit_nxt    = smpd_pkg::EXIT_BASE + {2'b00, sig_r};
              end
            end
            default: outcome_nxt = smpd_pkg::OUT_NONE;
          endcase
        end
      end

      smpd_pkg::ACT_TAKE: begin
        if (|grp_any) begin
          taken_nxt = {grp_sel, grp_idx[grp_sel]};
          pending_nxt[{grp_sel, grp_idx[grp_sel]}] = 1'b0;
        end else begin
          status_nxt = smpd_pkg::ST_NONE;
        end
      end

      smpd_pkg::ACT_READ: begin
        setout_nxt = pending_r & blocked_r;
      end

      default: status_nxt = smpd_pkg::ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_r   <= '0;
      pending_r   <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        blocked_r <= blocked_nxt;
        pending_r <= pending_nxt;
      end
      if (tbl_we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_nxt;
      outcome_r <= outcome_nxt;
      exit_r    <= exit_nxt;
      okind_r   <= okind_nxt;
      oinfo_r   <= oinfo_nxt;
      oreset_r  <= oreset_nxt;
      setout_r  <= setout_nxt;
      taken_r   <= taken_nxt;
    end
  end

  assign sts.out_blocked = out_valid_r && out_stall;

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_outcome        = outcome_r;
  assign out_exit_code      = exit_r;
  assign out_old_kind       = okind_r;
  assign out_old_info_flag  = oinfo_r;
  assign out_old_reset_flag = oreset_r;
  assign out_set_out        = setout_r;
  assign out_taken_signal   = taken_r;

endmodule

@@ hdl/signal_mask_pending_dispatcher_core.sv @@
// Signal disposition / mask / pending dispatcher. Each input beat is one request
// (set disposition, change mask, deliver, take lowest pending, read pending) and
// gives exactly one result beat. The accepting edge captures the beat and starts
// the registered read of the disposition table; the commit in the exec state then
// updates state and loads the output register, and waits while that register is
// full and stalled. A new item is taken only once the last one has committed;
// a finished result may wait in the output register while the next item is taken.
// Input is held off while reset is asserted. Table entries carry valid bits cleared at reset, so no clearing pass.
// Depends on smpd_pkg, smpd_ctrl, smpd_dp, smpd_ram.
module signal_mask_pending_dispatcher_core #(
  parameter int NUM_SIGNALS = smpd_pkg::NUM_SIGNALS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_action,
  input  logic [5:0]                 in_signal_number,
  input  logic [1:0]                 in_disposition_kind,
  input  logic                       in_wants_info,
  input  logic                       in_reset_once,
  input  logic [1:0]                 in_mask_how,
  input  logic                       in_mask_given,
  input  logic [smpd_pkg::SET_W-1:0] in_signal_set,
  input  logic                       in_info_given,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [3:0]                 out_outcome,
  output logic [7:0]                 out_exit_code,
  output logic [1:0]                 out_old_kind,
  output logic                       out_old_info_flag,
  output logic                       out_old_reset_flag,
  output logic [smpd_pkg::SET_W-1:0] out_set_out,
  output logic [5:0]                 out_taken_signal
);

  smpd_pkg::cmd_t cmd;
  smpd_pkg::sts_t sts;

  smpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  smpd_dp #(
    .NUM_SIGNALS (NUM_SIGNALS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_signal_number    (in_signal_number),
    .in_disposition_kind (in_disposition_kind),
    .in_wants_info       (in_wants_info),
    .in_reset_once       (in_reset_once),
    .in_mask_how         (in_mask_how),
    .in_mask_given       (in_mask_given),
    .in_signal_set       (in_signal_set),
    .in_info_given       (in_info_given),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_outcome         (out_outcome),
    .out_exit_code       (out_exit_code),
    .out_old_kind        (out_old_kind),
    .out_old_info_flag   (out_old_info_flag),
    .out_old_reset_flag  (out_old_reset_flag),
    .out_set_out         (out_set_out),
    .out_taken_signal    (out_taken_signal)
  );

  // an accepted beat keeps the input side busy for its commit cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after accept");

  // exit code present exactly on terminate
  a_exit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_outcome == smpd_pkg::OUT_TERMINATE) == (out_exit_code != 8'd0)))
    else $error("exit code does not match outcome");

  // a delivery outcome or a taken signal only comes with ok status
  a_outcome_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome != smpd_pkg::OUT_NONE || out_taken_signal != 6'd0))
      |-> (out_status == smpd_pkg::ST_OK))
    else $error("outcome or taken signal with non-ok status");

  // taken signal stays within the configured signal range
  a_taken_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_taken_signal} < 7'(NUM_SIGNALS)))
    else $error("taken signal out of range");

endmodule

@@ tb/sv/tb_signal_mask_pending_dispatcher_core.sv @@
// Testbench for signal_mask_pending_dispatcher_core: directed and random request beats,
// with a request-level shadow of dispositions, blocked and pending masks checking every result.
// Depends on smpd_pkg and the core RTL.
module tb_signal_mask_pending_dispatcher_core;
  import smpd_pkg::*;

  localparam int          NSIG           = NUM_SIGNALS_DEF;
  localparam int          CYCLE_LIMIT    = 300000;
  localparam int          ITEMS_PER_PASS = 660;
  localparam logic [2:0]  ACT_UNKNOWN_LO = 3'd5;
  localparam logic [2:0]  ACT_UNKNOWN_HI = 3'd7;
  localparam logic [1:0]  HOW_BAD        = 2'd3;

  typedef struct packed {
    logic [2:0]       action;
    logic [5:0]       sig;
    logic [1:0]       kind;
    logic             winfo;
    logic             wreset;
    logic [1:0]       how;
    logic             given;
    logic [SET_W-1:0] sset;
    logic             ginfo;
  } disp_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       outcome;
    logic [7:0]       exit_code;
    logic [1:0]       old_kind;
    logic             old_info;
    logic             old_reset;
    logic [SET_W-1:0] set_out;
    logic [5:0]       taken;
  } disp_result_t;

  logic             clk;
  logic             rst_n               = 1'b0;
  logic             in_valid            = 1'b0;
  logic             in_stall;
  logic [2:0]       in_action           = '0;
  logic [5:0]       in_signal_number    = '0;
  logic [1:0]       in_disposition_kind = '0;
  logic             in_wants_info       = 1'b0;
  logic             in_reset_once       = 1'b0;
  logic [1:0]       in_mask_how         = '0;
  logic             in_mask_given       = 1'b0;
  logic [SET_W-1:0] in_signal_set       = '0;
  logic             in_info_given       = 1'b0;
  logic             out_valid;
  logic             out_stall           = 1'b0;
  logic [1:0]       out_status;
  logic [3:0]       out_outcome;
  logic [7:0]       out_exit_code;
  logic [1:0]       out_old_kind;
  logic             out_old_info_flag;
  logic             out_old_reset_flag;
  logic [SET_W-1:0] out_set_out;
  logic [5:0]       out_taken_signal;

  // shadow state of the dispatcher
  logic [ENTRY_W-1:0] disp_shadow [64];
  logic [SET_W-1:0]   blocked_shadow;
  logic [SET_W-1:0]   pending_shadow;

  disp_result_t pending_results [$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           send_gap_pct   = 0;
  int           recv_stall_pct = 0;

  signal_mask_pending_dispatcher_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_signal_number    (in_signal_number),
    .in_disposition_kind (in_disposition_kind),
    .in_wants_info       (in_wants_info),
    .in_reset_once       (in_reset_once),
    .in_mask_how         (in_mask_how),
    .in_mask_given       (in_mask_given),
    .in_signal_set       (in_signal_set),
    .in_info_given       (in_info_given),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_outcome         (out_outcome),
    .out_exit_code       (out_exit_code),
    .out_old_kind        (out_old_kind),
    .out_old_info_flag   (out_old_info_flag),
    .out_old_reset_flag  (out_old_reset_flag),
    .out_set_out         (out_set_out),
    .out_taken_signal    (out_taken_signal)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void reset_shadow();
    for (int i = 0; i < 64; i++) disp_shadow[i] = {2'b00, KIND_DEFAULT};
    disp_shadow[SN_CHLD] = {2'b00, KIND_IGNORE};
    disp_shadow[SN_PIPE] = {2'b00, KIND_IGNORE};
    blocked_shadow = '0;
    pending_shadow = '0;
  endfunction

  // Advances the shadow state by one request and returns the result it must give.
  function automatic disp_result_t predict_dispatch(disp_req_t r);
    disp_result_t       res;
    logic [ENTRY_W-1:0] ent;
    logic [SET_W-1:0]   cand;
    logic               sig_ok;
    res    = '0;
    sig_ok = (r.sig != 6'd0) && (int'(r.sig) < NSIG);
    case (r.action)
      ACT_SET_DISP: begin
        if (!sig_ok || r.sig == SN_KILL || r.sig == SN_STOP) begin
          res.status = ST_INVALID;
        end else begin
          ent           = disp_shadow[r.sig];
          res.old_kind  = ent[1:0];
          res.old_info  = ent[2];
          res.old_reset = ent[3];
          if (r.kind == KIND_BAD) res.status = ST_INVALID;
          else disp_shadow[r.sig] = {r.wreset, r.winfo, r.kind};
        end
      end
      ACT_MASK: begin
        res.set_out = blocked_shadow;
        if (r.given) begin
          case (r.how)
            HOW_BLOCK:   blocked_shadow = blocked_shadow | r.sset;
            HOW_UNBLOCK: blocked_shadow = blocked_shadow & ~r.sset;
            HOW_SET:     blocked_shadow = r.sset;
            default:     res.status = ST_INVALID;
          endcase
          if (res.status == ST_OK) blocked_shadow = blocked_shadow & ~KILL_STOP_MASK;
        end
      end
      ACT_DELIVER: begin
        if (!sig_ok) begin
          res.status = ST_INVALID;
        end else if (blocked_shadow[r.sig]) begin
          pending_shadow[r.sig] = 1'b1;
          res.outcome = OUT_LATCHED;
        end else begin
          ent = disp_shadow[r.sig];
          case (ent[1:0])
            KIND_IGNORE: res.outcome = OUT_IGNORED;
            KIND_HANDLER: begin
              if (ent[2]) res.outcome = r.ginfo ? OUT_HANDLER_I : OUT_NONE;
              else res.outcome = OUT_HANDLER;
              if (ent[3]) disp_shadow[r.sig] = {1'b1, 1'b0, KIND_DEFAULT};
            end
            KIND_DEFAULT: begin
              if (r.sig == SN_CHLD || r.sig == SN_URG || r.sig == SN_WINCH)
                res.outcome = OUT_DFL_IGN;
              else if (r.sig == SN_STOP || r.sig == SN_TSTP || r.sig == SN_TTIN ||
                       r.sig == SN_TTOU)
                res.outcome = OUT_STOP;
              else if (r.sig == SN_CONT)
                res.outcome = OUT_CONT;
              else begin
                res.outcome   = OUT_TERMINATE;
                res.exit_code = EXIT_BASE + {2'b00, r.sig};
              end
            end
            default: res.outcome = OUT_NONE;
          endcase
        end
      end
      ACT_TAKE: begin
        cand       = pending_shadow & r.sset & ~blocked_shadow;
        res.status = ST_NONE;
        for (int n = 1; n < NSIG; n++) begin
          if (cand[n]) begin
            pending_shadow[n] = 1'b0;
            res.taken         = 6'(n);
            res.status        = ST_OK;
            break;
          end
        end
      end
      ACT_READ: res.set_out = pending_shadow & blocked_shadow;
      default:  res.status = ST_INVALID;
    endcase
    return res;
  endfunction

  // One request beat; called at a falling edge, returns at a falling edge with valid held.
  task automatic send_request(input disp_req_t r);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_action           = r.action;
    in_signal_number    = r.sig;
    in_disposition_kind = r.kind;
    in_wants_info       = r.winfo;
    in_reset_once       = r.wreset;
    in_mask_how         = r.how;
    in_mask_given       = r.given;
    in_signal_set       = r.sset;
    in_info_given       = r.ginfo;
    in_valid            = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(predict_dispatch(r));
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    disp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("outcome", 64'(want.outcome), 64'(out_outcome));
        check_field("exit_code", 64'(want.exit_code), 64'(out_exit_code));
        check_field("old_kind", 64'(want.old_kind), 64'(out_old_kind));
        check_field("old_info_flag", 64'(want.old_info), 64'(out_old_info_flag));
        check_field("old_reset_flag", 64'(want.old_reset), 64'(out_old_reset_flag));
        check_field("set_out", want.set_out, out_set_out);
        check_field("taken_signal", 64'(want.taken), 64'(out_taken_signal));
      end
    end
  end

  function automatic disp_req_t blank_req(input logic [2:0] act);
    disp_req_t r;
    r        = '0;
    r.action = act;
    return r;
  endfunction

  task automatic send_set_disp(input logic [5:0] sig, input logic [1:0] kind,
                               input logic winfo, input logic wreset);
    disp_req_t r;
    r        = blank_req(ACT_SET_DISP);
    r.sig    = sig;
    r.kind   = kind;
    r.winfo  = winfo;
    r.wreset = wreset;
    send_request(r);
  endtask

  task automatic send_mask(input logic [1:0] how, input logic given,
                           input logic [SET_W-1:0] sset);
    disp_req_t r;
    r       = blank_req(ACT_MASK);
    r.how   = how;
    r.given = given;
    r.sset  = sset;
    send_request(r);
  endtask

  task automatic send_deliver(input logic [5:0] sig, input logic ginfo);
    disp_req_t r;
    r       = blank_req(ACT_DELIVER);
    r.sig   = sig;
    r.ginfo = ginfo;
    send_request(r);
  endtask

  task automatic send_take(input logic [SET_W-1:0] sset);
    disp_req_t r;
    r      = blank_req(ACT_TAKE);
    r.sset = sset;
    send_request(r);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // biased toward the numbers with their own default action
  function automatic logic [5:0] pick_signal();
    if ($urandom_range(99) >= 35) return 6'($urandom_range(63));
    case ($urandom_range(12))
      0:       return SN_KILL;
      1:       return SN_PIPE;
      2:       return SN_CHLD;
      3:       return SN_CONT;
      4:       return SN_STOP;
      5:       return SN_TSTP;
      6:       return SN_TTIN;
      7:       return SN_TTOU;
      8:       return SN_URG;
      9:       return SN_WINCH;
      10:      return 6'd0;
      11:      return 6'd1;
      default: return 6'd63;
    endcase
  endfunction

  function automatic logic [SET_W-1:0] pick_set();
    case ($urandom_range(3))
      0, 1:    return {$urandom, $urandom};
      2:       return SET_W'(1) << $urandom_range(63);
      default: return '1;
    endcase
  endfunction

  function automatic disp_req_t random_req();
    disp_req_t r;
    int        pick;
    r      = '0;
    pick   = $urandom_range(99);
    if (pick < 20)      r.action = ACT_SET_DISP;
    else if (pick < 35) r.action = ACT_MASK;
    else if (pick < 70) r.action = ACT_DELIVER;
    else if (pick < 85) r.action = ACT_TAKE;
    else if (pick < 93) r.action = ACT_READ;
    else                r.action = 3'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
    r.sig    = pick_signal();
    r.kind   = 2'($urandom_range(3));
    r.winfo  = 1'($urandom_range(1));
    r.wreset = 1'($urandom_range(1));
    r.how    = 2'($urandom_range(3));
    r.given  = ($urandom_range(99) < 85);
    r.sset   = pick_set();
    r.ginfo  = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic test_reset_dispositions();
    send_deliver(SN_CHLD, 1'b0);
    send_deliver(6'd1, 1'b0);
    send_deliver(6'd63, 1'b1);
    send_deliver(6'd0, 1'b0);
    send_deliver(SN_STOP, 1'b0);
    send_deliver(SN_CONT, 1'b0);
    send_deliver(SN_URG, 1'b0);
  endtask

  task automatic test_set_disposition();
    send_set_disp(6'd0, KIND_HANDLER, 1'b0, 1'b0);
    send_set_disp(SN_KILL, KIND_IGNORE, 1'b0, 1'b0);
    send_set_disp(SN_STOP, KIND_IGNORE, 1'b1, 1'b1);
    // info handler without a record is skipped, then reverts to default once
    send_set_disp(6'd5, KIND_HANDLER, 1'b1, 1'b1);
    send_deliver(6'd5, 1'b0);
    send_deliver(6'd5, 1'b0);
    send_set_disp(6'd5, KIND_BAD, 1'b1, 1'b0);
    send_set_disp(6'd62, KIND_HANDLER, 1'b1, 1'b0);
    send_deliver(6'd62, 1'b1);
    send_set_disp(6'd62, KIND_HANDLER, 1'b0, 1'b0);
    send_deliver(6'd62, 1'b0);
  endtask

  task automatic test_mask_change();
    send_mask(HOW_BLOCK, 1'b0, '1);
    send_mask(HOW_BAD, 1'b1, '1);
    send_mask(HOW_BLOCK, 1'b1, '1);
    send_mask(HOW_UNBLOCK, 1'b0, '0);
  endtask

  task automatic test_pending_take();
    disp_req_t r;
    send_deliver(6'd2, 1'b0);
    send_deliver(6'd63, 1'b0);
    send_deliver(SN_KILL, 1'b0);
    r = blank_req(ACT_READ);
    send_request(r);
    send_take('1);
    send_mask(HOW_UNBLOCK, 1'b1, SET_W'(1) << 63);
    send_take('1);
    send_mask(HOW_SET, 1'b1, '0);
    send_take('1);
    send_take('1);
  endtask

  task automatic test_unknown_action();
    disp_req_t r;
    r = random_req();
    r.action = ACT_UNKNOWN_LO;
    send_request(r);
    r = random_req();
    r.action = ACT_UNKNOWN_HI;
    send_request(r);
  endtask

  task automatic test_random_traffic(input int n_items);
    disp_req_t  r;
    logic [5:0] sig;
    int         sent;
    int         reps;
    sent = 0;
    while (sent < n_items) begin
      sig = pick_signal();
      case ($urandom_range(3))
        0: begin
          // install a handler and fire it a few times
          send_set_disp(sig, ($urandom_range(99) < 80) ? KIND_HANDLER : 2'($urandom_range(3)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
          reps = $urandom_range(1, 3);
          repeat (reps) send_deliver(sig, 1'($urandom_range(1)));
          sent += reps + 1;
        end
        1: begin
          // block, latch, inspect, unblock and take
          send_mask(HOW_BLOCK, 1'b1, (SET_W'(1) << sig) | pick_set());
          send_deliver(sig, 1'($urandom_range(1)));
          send_deliver(pick_signal(), 1'b0);
          r = blank_req(ACT_READ);
          send_request(r);
          send_mask(($urandom_range(1) != 0) ? HOW_UNBLOCK : HOW_SET, 1'b1, pick_set());
          send_take(($urandom_range(1) != 0) ? (SET_W'(1) << sig) : pick_set());
          sent += 6;
        end
        default: begin
          send_request(random_req());
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_gap_pct   = 9;
    recv_stall_pct = 49;
    test_reset_dispositions();
    test_set_disposition();
    test_mask_change();
    test_pending_take();
    test_unknown_action();
    test_random_traffic(ITEMS_PER_PASS);

    // sender holds off until the block has emptied
    in_valid = 1'b0;
    wait_drained();
    send_gap_pct   = 49;
    recv_stall_pct = 9;
    test_random_traffic(ITEMS_PER_PASS);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_traffic(ITEMS_PER_PASS);

    in_valid = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
